[rtl/utf8d_pkg.sv]
`default_nettype none

package utf8d_pkg;

    localparam int WIN_LEN    = 6;
    localparam int PEND_DEPTH = 5;
    localparam int MAX_RES    = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [20:0] ERR_CODE = 21'd63;

    localparam logic [1:0] REG_REJECT_CESU = 2'd0;

    typedef logic [7:0] byte_t;
    typedef byte_t [WIN_LEN-1:0] win_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        error;
        logic [2:0]  byte_count;
        logic        cesu_pair;
        logic        last_result;
    } out_t;

    typedef struct packed {
        logic        settled;
        logic [20:0] code_point;
        logic        error;
        logic [2:0]  byte_count;
        logic        cesu_pair;
    } head_t;

    typedef struct packed {
        logic [QPTR_W:0] count;
        logic            room;
    } qstat_t;

endpackage

`default_nettype wire

[rtl/utf8_cesu8_decoder_top.sv]
`default_nettype none

// Streaming UTF-8 decoder that takes one byte per transaction and delivers one result per
// transaction: a code point, or 63 with error set, plus the byte count of its sequence.
// A byte is registered, then decoded together with up to five held bytes, which settles
// zero to three results into a four-entry result queue. The input accepts a byte every
// cycle while the queue holds at most one result, so ordinary text runs at one byte per
// cycle through the input register and the result queue; a byte that settles several
// results delivers them one at a time on the single output port, and input stalls once
// the queue backs up. No clearing pass is needed after reset.
module utf8_cesu8_decoder_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  var  utf8d_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output utf8d_pkg::out_t   out_data,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NR = utf8d_pkg::MAX_RES;

    utf8d_pkg::in_t   in_data_reg;
    logic             in_valid_reg;
    logic             adv;
    logic             reject;

    utf8d_pkg::byte_t [utf8d_pkg::PEND_DEPTH-1:0] pend_reg;
    logic [2:0]       pend_cnt_reg;
    logic [2:0]       pend_cnt_next;

    utf8d_pkg::win_t  win0;
    utf8d_pkg::win_t  win   [NR+1];
    logic [2:0]       n     [NR+1];
    logic             run   [NR+1];
    logic             valid [NR+1];
    utf8d_pkg::head_t hd    [NR];

    utf8d_pkg::out_t [NR-1:0] push_data;
    logic [1:0]       push_num;
    utf8d_pkg::qstat_t qstat;

    utf8d_regs u_regs (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .reject_cesu_pairs (reject)
    );

    assign adv      = in_valid_reg && qstat.room;
    assign in_stall = in_valid_reg && !qstat.room;

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        win0 = '0;
        win0[utf8d_pkg::PEND_DEPTH-1:0] = pend_reg;
        win0[pend_cnt_reg] = in_data_reg.byte_in;
    end

    assign win[0]     = win0;
    assign n[0]       = pend_cnt_reg + 3'd1;
    assign run[0]     = 1'b1;
    assign valid[NR]  = 1'b0;
    assign run[NR]    = 1'b0;

    for (genvar k = 0; k < NR; k++)
    begin : g_stage
        logic [2:0]      cnt;
        logic [3:0]      idx;
        utf8d_pkg::win_t nxt;

        utf8d_head u_head (
            .win    (win[k]),
            .n      (n[k]),
            .fin    (in_data_reg.end_of_string),
            .reject (reject),
            .hd     (hd[k])
        );

        assign valid[k] = run[k] && hd[k].settled;
        assign cnt      = (hd[k].byte_count > n[k]) ? n[k] : hd[k].byte_count;

        always_comb
        begin
            nxt = '0;
            idx = '0;
            for (int i = 0; i < utf8d_pkg::WIN_LEN; i++)
            begin
                idx = 4'(i) + {1'b0, cnt};
                if (!valid[k])
                begin
                    nxt[i] = win[k][i];
                end
                else if (idx < 4'(utf8d_pkg::WIN_LEN))
                begin
                    nxt[i] = win[k][idx[2:0]];
                end
            end
        end

        assign win[k+1] = nxt;
        assign n[k+1]   = valid[k] ? n[k] - cnt : n[k];
        if (k + 1 < NR)
        begin : g_run
            assign run[k+1] = valid[k] && (n[k+1] != 3'd0);
        end

        assign push_data[k].code_point  = hd[k].code_point;
        assign push_data[k].error       = hd[k].error;
        assign push_data[k].byte_count  = cnt;
        assign push_data[k].cesu_pair   = hd[k].cesu_pair;
        assign push_data[k].last_result = valid[k] && !valid[k+1];
    end

    always_comb
    begin
        push_num = '0;
        if (adv)
        begin
            for (int k = 0; k < NR; k++)
            begin
                push_num = push_num + 2'(valid[k]);
            end
        end
    end

    assign pend_cnt_next = (n[NR] > 3'(utf8d_pkg::PEND_DEPTH)) ?
                           3'(utf8d_pkg::PEND_DEPTH) : n[NR];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pend_reg <= win[NR][utf8d_pkg::PEND_DEPTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else if (adv)
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    utf8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_num    (push_num),
        .wr_data   (push_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .status    (qstat)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= 3'(utf8d_pkg::QDEPTH))
        else $error("result queue holds more entries than it has");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= 3'(utf8d_pkg::PEND_DEPTH))
        else $error("held byte count exceeds the buffer");

    a_pend_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && push_num == 2'd0) |=> pend_cnt_reg == $past(pend_cnt_reg) + 3'd1)
        else $error("a byte that settles nothing was not held");

endmodule

`default_nettype wire

[rtl/utf8d_head.sv]
`default_nettype none

module utf8d_head (
    input  var utf8d_pkg::win_t  win,
    input  wire logic [2:0]      n,
    input  wire logic            fin,
    input  wire logic            reject,
    output utf8d_pkg::head_t     hd
);

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic valid_scalar(input logic [20:0] v);
        return (v < 21'h110000) && (v[20:11] != 10'h01B) && (v[15:1] != 15'h7FFF) &&
               !((v >= 21'h00FDD0) && (v <= 21'h00FDEF));
    endfunction

    always_comb
    begin
        logic [20:0] v;
        logic [20:0] minv;
        logic [15:0] v3;
        logic        chk;
        v    = '0;
        minv = '0;
        chk  = 1'b0;
        v3   = {win[0][3:0], win[1][5:0], win[2][5:0]};
        hd.settled    = 1'b1;
        hd.code_point = utf8d_pkg::ERR_CODE;
        hd.error      = 1'b1;
        hd.byte_count = 3'd1;
        hd.cesu_pair  = 1'b0;
        if (win[0] < 8'h80)
        begin
            hd.code_point = {13'd0, win[0]};
            hd.error      = 1'b0;
        end
        else if (win[0] < 8'hC0 || win[0] > 8'hF7)
        begin
            hd.settled = 1'b1;
        end
        else if (n < 3'd2)
        begin
            hd.settled = fin;
        end
        else if (!is_cont(win[1]))
        begin
            hd.settled = 1'b1;
        end
        else if (win[0] < 8'hE0)
        begin
            v             = {10'd0, win[0][4:0], win[1][5:0]};
            minv          = 21'h80;
            chk           = 1'b1;
            hd.byte_count = 3'd2;
        end
        else
        begin
            hd.byte_count = 3'd2;
            if (n < 3'd3)
            begin
                hd.settled = fin;
            end
            else if (!is_cont(win[2]))
            begin
                hd.settled = 1'b1;
            end
            else if (win[0] < 8'hF0)
            begin
                v             = {5'd0, v3};
                minv          = 21'h800;
                chk           = 1'b1;
                hd.byte_count = 3'd3;
                // A high surrogate waits for an encoded low surrogate to merge with.
                if (v3[15:10] == 6'b110110)
                begin
                    if (n < 3'd4)
                    begin
                        hd.settled = fin;
                    end
                    else if (win[3] == 8'hED)
                    begin
                        if (n < 3'd5)
                        begin
                            hd.settled = fin;
                        end
                        else if (win[4][7:4] == 4'hB)
                        begin
                            if (n < 3'd6)
                            begin
                                hd.settled = fin;
                            end
                            else if (is_cont(win[5]))
                            begin
                                v = 21'h10000 +
                                    {1'b0, v3[9:0], win[4][3:0], win[5][5:0]};
                                minv          = 21'h10000;
                                hd.byte_count = 3'd6;
                                hd.cesu_pair  = 1'b1;
                            end
                        end
                    end
                end
            end
            else
            begin
                hd.byte_count = 3'd3;
                if (n < 3'd4)
                begin
                    hd.settled = fin;
                end
                else if (!is_cont(win[3]))
                begin
                    hd.settled = 1'b1;
                end
                else
                begin
                    v = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
                    minv          = 21'h10000;
                    chk           = 1'b1;
                    hd.byte_count = 3'd4;
                end
            end
        end
        if (chk && v >= minv && valid_scalar(v) && !(hd.cesu_pair && reject))
        begin
            hd.code_point = v;
            hd.error      = 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/utf8d_queue.sv]
`default_nettype none

module utf8d_queue (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic [1:0]                              wr_num,
    input  var  utf8d_pkg::out_t [utf8d_pkg::MAX_RES-1:0] wr_data,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output utf8d_pkg::out_t                              out_data,
    output utf8d_pkg::qstat_t                            status
);

    localparam int PW = utf8d_pkg::QPTR_W;

    utf8d_pkg::out_t mem [utf8d_pkg::QDEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   tail_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;
    logic            pop;

    assign out_valid     = count_reg != '0;
    assign out_data      = mem[head_reg];
    assign pop           = out_valid && !out_stall;
    assign count_next    = count_reg + (PW + 1)'(wr_num) - (PW + 1)'(pop);
    assign status.count  = count_reg;
    assign status.room   = count_reg <= (PW + 1)'(utf8d_pkg::QDEPTH - utf8d_pkg::MAX_RES);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < utf8d_pkg::MAX_RES; k++)
        begin
            if (k < int'(wr_num))
            begin
                mem[tail_reg + PW'(k)] <= wr_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + PW'(pop);
            tail_reg  <= tail_reg + PW'(wr_num);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/utf8d_regs.sv]
`default_nettype none

module utf8d_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic             reject_cesu_pairs
);

    logic reject_reg;

    assign pready            = 1'b1;
    assign reject_cesu_pairs = reject_reg;
    assign prdata = (paddr == utf8d_pkg::REG_REJECT_CESU) ? {31'd0, reject_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == utf8d_pkg::REG_REJECT_CESU)
        begin
            reject_reg <= pwdata[0];
        end
    end

endmodule

`default_nettype wire
